// File: hw/rtl/rcl_pkg.sv
// ----------------------------------------------------------------------------
// rcl_pkg
// Shared types and constants of the row cell legalizer: datapath commands,
// status bits, coordinate widths and register indexes.
// ----------------------------------------------------------------------------
package rcl_pkg;

   localparam int X_W     = 32;   // cell and row coordinates
   localparam int WID_W   = 20;   // cell width
   localparam int STEP_W  = 16;   // site pitch
   localparam int SCNT_W  = 24;   // site count
   localparam int IDX_W   = 6;    // reported cell index
   localparam int COORD_W = 48;   // exact internal coordinate range
   localparam int REM_W   = STEP_W;
   localparam int DIV_STEPS = X_W;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef enum logic [1:0] {
      REG_ORIGIN = 2'd0,
      REG_STEP   = 2'd1,
      REG_COUNT  = 2'd2
   } reg_index_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_RI,
      OP_RLATCH,
      OP_RSCAN,
      OP_RWRITE,
      OP_SINIT,
      OP_SROW,
      OP_SEGA,
      OP_SEGB,
      OP_SEGC,
      OP_SEGD,
      OP_SEGE,
      OP_SEGNEXT,
      OP_MVA,
      OP_MVB,
      OP_MVC,
      OP_DIV,
      OP_PLACE,
      OP_EMRD,
      OP_EMLD
   } op_type;

   typedef struct packed {
      logic i_last;
      logic scan_done;
      logic seg_empty;
      logic seg_last;
      logic mv_done;
      logic beyond;
      logic left_of;
      logic step_zero;
      logic div_done;
      logic out_busy;
      logic e_last;
   } stat_type;

   function automatic coord_type sx32(input logic [X_W-1:0] v);
      sx32 = {{(COORD_W-X_W){v[X_W-1]}}, v};
   endfunction

endpackage

// File: hw/rtl/rcl_ram.sv
// ----------------------------------------------------------------------------
// rcl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rcl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hw/rtl/rcl_ctrl.sv
// ----------------------------------------------------------------------------
// rcl_ctrl
// Sequencer of the legalizer: load, rank sort, segment sweep, emit.
// ----------------------------------------------------------------------------
module rcl_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tlast,
   input  rcl_pkg::stat_type stat,
   output logic             req_tready,
   output rcl_pkg::op_type  cmd
);
   import rcl_pkg::*;

   typedef enum logic [4:0] {
      S_LOAD, S_RI, S_RLATCH, S_RSCAN, S_RWRITE, S_SINIT, S_SROW,
      S_SEGA, S_SEGB, S_SEGC, S_SEGD, S_SEGE, S_SEGNEXT,
      S_MVA, S_MVB, S_MVC, S_DIV, S_PLACE, S_EMRD, S_EMLD
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = OP_NONE;
      unique case (state_ff)
         S_LOAD: begin
            if (req_tvalid) begin
               cmd = OP_LOAD;
               if (req_tlast) state_in = S_RI;
            end
         end
         S_RI:     begin cmd = OP_RI;     state_in = S_RLATCH; end
         S_RLATCH: begin cmd = OP_RLATCH; state_in = S_RSCAN; end
         S_RSCAN: begin
            cmd = OP_RSCAN;
            if (stat.scan_done) state_in = S_RWRITE;
         end
         S_RWRITE: begin
            cmd = OP_RWRITE;
            state_in = stat.i_last ? S_SINIT : S_RI;
         end
         S_SINIT: begin cmd = OP_SINIT; state_in = S_SROW; end
         S_SROW:  begin cmd = OP_SROW;  state_in = S_SEGA; end
         S_SEGA:  begin cmd = OP_SEGA;  state_in = S_SEGB; end
         S_SEGB:  begin cmd = OP_SEGB;  state_in = S_SEGC; end
         S_SEGC:  begin cmd = OP_SEGC;  state_in = S_SEGD; end
         S_SEGD:  begin cmd = OP_SEGD;  state_in = S_SEGE; end
         S_SEGE: begin
            cmd = OP_SEGE;
            state_in = stat.seg_empty ? S_SEGNEXT : S_MVA;
         end
         S_SEGNEXT: begin
            cmd = OP_SEGNEXT;
            state_in = stat.seg_last ? S_EMRD : S_SEGA;
         end
         S_MVA: begin
            if (stat.mv_done) begin
               state_in = S_SEGNEXT;
            end else begin
               cmd = OP_MVA;
               state_in = S_MVB;
            end
         end
         S_MVB: begin cmd = OP_MVB; state_in = S_MVC; end
         S_MVC: begin
            cmd = OP_MVC;
            priority if (stat.beyond) state_in = S_SEGNEXT;
            else if (stat.left_of)    state_in = S_MVA;
            else if (stat.step_zero)  state_in = S_PLACE;
            else                      state_in = S_DIV;
         end
         S_DIV: begin
            cmd = OP_DIV;
            if (stat.div_done) state_in = S_PLACE;
         end
         S_PLACE: begin cmd = OP_PLACE; state_in = S_MVA; end
         S_EMRD: begin
            if (!stat.out_busy) begin
               cmd = OP_EMRD;
               state_in = S_EMLD;
            end
         end
         S_EMLD: begin
            cmd = OP_EMLD;
            state_in = stat.e_last ? S_LOAD : S_EMRD;
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_LOAD);
endmodule

// File: hw/rtl/rcl_dp.sv
// ----------------------------------------------------------------------------
// rcl_dp
// Datapath of the legalizer: cell stores, rank counters, segment edges,
// remainder divider for site snapping, clamp and the result register.
// ----------------------------------------------------------------------------
module rcl_dp #(
   parameter int MAX_CELLS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rcl_pkg::op_type                cmd,
   output rcl_pkg::stat_type              stat,
   input  logic [rcl_pkg::X_W-1:0]        cfg_origin,
   input  logic [rcl_pkg::STEP_W-1:0]     cfg_step,
   input  logic [rcl_pkg::SCNT_W-1:0]     cfg_count,
   input  logic [rcl_pkg::X_W-1:0]        in_x,
   input  logic [rcl_pkg::WID_W-1:0]      in_width,
   input  logic                           in_fixed,
   input  logic                           rsp_tready,
   output logic                           rsp_tvalid,
   output logic [rcl_pkg::IDX_W-1:0]      out_index,
   output logic [rcl_pkg::X_W-1:0]        out_x,
   output logic                           out_last
);
   import rcl_pkg::*;

   localparam int AW = $clog2(MAX_CELLS);
   localparam int CW = $clog2(MAX_CELLS + 1);

   // stores
   logic          pos_we, attr_we, ord_we;
   logic [AW-1:0] pos_wa, attr_wa, ord_wa, caddr, oaddr;
   logic [X_W-1:0] pos_wd, pos_rd;
   logic [WID_W:0] attr_rd;
   logic [AW-1:0]  ord_wd, ord_rd;

   // control counters
   logic [CW-1:0] cnt_ff, cnt_in, nf_ff, nf_in;
   logic [CW-1:0] j_ff, j_in, k_ff, k_in, mv_ff, mv_in;
   logic [AW-1:0] i_ff, i_in, jd_ff, jd_in, rank_ff, rank_in, id_ff, id_in;
   logic [AW-1:0] e_ff, e_in;
   logic          cmpv_ff, cmpv_in, fi_ff, fi_in;
   logic          out_valid_ff, out_valid_in;
   logic [5:0]    dcnt_ff, dcnt_in;

   // payload
   logic [X_W-1:0]   xi_ff, xi_in, x_ff, x_in;
   logic [WID_W-1:0] w_ff, w_in;
   coord_type        segl_ff, segl_in, segr_ff, segr_in, cur_ff, cur_in;
   coord_type        rowr_ff, rowr_in;
   logic [STEP_W+SCNT_W-1:0] prod_ff, prod_in;
   logic [X_W-1:0]   dvd_ff, dvd_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic             dneg_ff, dneg_in;
   logic [IDX_W-1:0] oidx_ff, oidx_in;
   logic [X_W-1:0]   ox_ff, ox_in;
   logic             olast_ff, olast_in;

   // combinational helpers
   coord_type  pos_c, seg_edge, diff, mag, snapped, t0, t1, t2, rb;
   logic [X_W-1:0] t_sat;
   logic [REM_W:0] rem_t;
   logic           same_class, before_i;

   rcl_ram #(.WIDTH(X_W), .DEPTH(MAX_CELLS)) u_pos (
      .clock, .wr_en(pos_we), .wr_addr(pos_wa), .wr_data(pos_wd),
      .rd_addr(caddr), .rd_data(pos_rd));
   rcl_ram #(.WIDTH(WID_W + 1), .DEPTH(MAX_CELLS)) u_attr (
      .clock, .wr_en(attr_we), .wr_addr(attr_wa), .wr_data({in_fixed, in_width}),
      .rd_addr(caddr), .rd_data(attr_rd));
   rcl_ram #(.WIDTH(AW), .DEPTH(MAX_CELLS)) u_order (
      .clock, .wr_en(ord_we), .wr_addr(ord_wa), .wr_data(ord_wd),
      .rd_addr(oaddr), .rd_data(ord_rd));

   assign pos_c    = sx32(pos_rd);
   assign seg_edge = (k_ff < nf_ff) ? pos_c : rowr_ff;
   assign diff     = pos_c - sx32(cfg_origin);
   assign mag      = diff[COORD_W-1] ? -diff : diff;
   assign rem_t    = {rem_ff, dvd_ff[X_W-1]};

   // place: snap, push past cursor, clamp into segment, saturate
   assign snapped = dneg_ff ? sx32(x_ff) + coord_type'(rem_ff)
                            : sx32(x_ff) - coord_type'(rem_ff);
   assign rb = segr_ff - coord_type'(w_ff);
   assign t0 = (cur_ff > snapped) ? cur_ff : snapped;
   assign t1 = (t0 > rb) ? rb : t0;
   assign t2 = (t1 < segl_ff) ? segl_ff : t1;
   always_comb begin
      priority if (t2 > sx32(32'h7FFF_FFFF)) t_sat = 32'h7FFF_FFFF;
      else if (t2 < sx32(32'h8000_0000))     t_sat = 32'h8000_0000;
      else                                   t_sat = t2[X_W-1:0];
   end

   assign same_class = (attr_rd[WID_W] == fi_ff);
   assign before_i   = ($signed(pos_rd) < $signed(xi_ff)) ||
                       ((pos_rd == xi_ff) && (jd_ff < i_ff));

   always_comb begin
      stat.i_last    = ({{(CW-AW){1'b0}}, i_ff} == cnt_ff - CW'(1));
      stat.scan_done = (j_ff == cnt_ff) && !cmpv_ff;
      stat.seg_empty = (seg_edge <= segl_ff);
      stat.seg_last  = (k_ff == nf_ff);
      stat.mv_done   = (mv_ff == cnt_ff - nf_ff);
      stat.beyond    = (pos_c >= segr_ff);
      stat.left_of   = (pos_c < segl_ff);
      stat.step_zero = (cfg_step == '0);
      stat.div_done  = (dcnt_ff == 6'(DIV_STEPS - 1));
      stat.out_busy  = out_valid_ff;
      stat.e_last    = ({{(CW-AW){1'b0}}, e_ff} == cnt_ff - CW'(1));
   end

   always_comb begin
      cnt_in = cnt_ff;  nf_in = nf_ff;  j_in = j_ff;  k_in = k_ff;  mv_in = mv_ff;
      i_in = i_ff;  jd_in = jd_ff;  rank_in = rank_ff;  id_in = id_ff;  e_in = e_ff;
      cmpv_in = cmpv_ff;  fi_in = fi_ff;  dcnt_in = dcnt_ff;
      xi_in = xi_ff;  x_in = x_ff;  w_in = w_ff;
      segl_in = segl_ff;  segr_in = segr_ff;  cur_in = cur_ff;
      rowr_in = rowr_ff;  prod_in = prod_ff;
      dvd_in = dvd_ff;  rem_in = rem_ff;  dneg_in = dneg_ff;
      oidx_in = oidx_ff;  ox_in = ox_ff;  olast_in = olast_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      pos_we = 1'b0;  pos_wa = cnt_ff[AW-1:0];  pos_wd = in_x;
      attr_we = 1'b0;  attr_wa = cnt_ff[AW-1:0];
      ord_we = 1'b0;  ord_wa = rank_ff;  ord_wd = i_ff;
      caddr = '0;  oaddr = '0;

      unique case (cmd)
         OP_NONE: ;
         OP_LOAD: begin
            // drop cells beyond a full row
            if (cnt_ff < CW'(MAX_CELLS)) begin
               pos_we  = 1'b1;
               attr_we = 1'b1;
               cnt_in  = cnt_ff + CW'(1);
               if (in_fixed) nf_in = nf_ff + CW'(1);
            end
            i_in = '0;
         end
         OP_RI: caddr = i_ff;
         OP_RLATCH: begin
            xi_in = pos_rd;  fi_in = attr_rd[WID_W];
            j_in = '0;  cmpv_in = 1'b0;  rank_in = '0;
         end
         OP_RSCAN: begin
            caddr = j_ff[AW-1:0];
            if (cmpv_ff && same_class && before_i) rank_in = rank_ff + AW'(1);
            cmpv_in = (j_ff < cnt_ff);
            jd_in   = j_ff[AW-1:0];
            if (j_ff < cnt_ff) j_in = j_ff + CW'(1);
         end
         OP_RWRITE: begin
            // fixed cells rank from zero, movable cells after all fixed ones
            ord_we = 1'b1;
            ord_wa = fi_ff ? rank_ff : AW'(nf_ff + CW'(rank_ff));
            i_in   = i_ff + AW'(1);
         end
         OP_SINIT: begin
            prod_in = cfg_step * cfg_count;
            k_in = '0;  mv_in = '0;  e_in = '0;
         end
         OP_SROW: rowr_in = sx32(cfg_origin) + coord_type'(prod_ff);
         OP_SEGA: oaddr = AW'(k_ff - CW'(1));
         OP_SEGB: caddr = ord_rd;
         OP_SEGC: begin
            segl_in = (k_ff == '0) ? sx32(cfg_origin)
                                   : pos_c + coord_type'(attr_rd[WID_W-1:0]);
            oaddr = k_ff[AW-1:0];
         end
         OP_SEGD: caddr = ord_rd;
         OP_SEGE: begin
            segr_in = seg_edge;
            cur_in  = segl_ff;
         end
         OP_SEGNEXT: k_in = k_ff + CW'(1);
         OP_MVA: oaddr = AW'(nf_ff + mv_ff);
         OP_MVB: begin
            caddr = ord_rd;
            id_in = ord_rd;
         end
         OP_MVC: begin
            x_in = pos_rd;  w_in = attr_rd[WID_W-1:0];
            if (!stat.beyond) mv_in = mv_ff + CW'(1);
            dneg_in = diff[COORD_W-1];
            dvd_in  = mag[X_W-1:0];
            rem_in  = '0;
            dcnt_in = '0;
         end
         OP_DIV: begin
            // one remainder bit per cycle, restoring
            if (rem_t >= {1'b0, cfg_step}) rem_in = REM_W'(rem_t - {1'b0, cfg_step});
            else                           rem_in = rem_t[REM_W-1:0];
            dvd_in  = {dvd_ff[X_W-2:0], 1'b0};
            dcnt_in = dcnt_ff + 6'd1;
         end
         OP_PLACE: begin
            pos_we = 1'b1;
            pos_wa = id_ff;
            pos_wd = t_sat;
            cur_in = sx32(t_sat) + coord_type'(w_ff);
         end
         OP_EMRD: caddr = e_ff;
         OP_EMLD: begin
            out_valid_in = 1'b1;
            oidx_in  = IDX_W'(e_ff);
            ox_in    = pos_rd;
            olast_in = stat.e_last;
            e_in     = e_ff + AW'(1);
            if (stat.e_last) begin
               cnt_in = '0;
               nf_in  = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         nf_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         nf_ff        <= nf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff <= j_in;  k_ff <= k_in;  mv_ff <= mv_in;
      i_ff <= i_in;  jd_ff <= jd_in;  rank_ff <= rank_in;  id_ff <= id_in;
      e_ff <= e_in;  cmpv_ff <= cmpv_in;  fi_ff <= fi_in;  dcnt_ff <= dcnt_in;
      xi_ff <= xi_in;  x_ff <= x_in;  w_ff <= w_in;
      segl_ff <= segl_in;  segr_ff <= segr_in;  cur_ff <= cur_in;
      rowr_ff <= rowr_in;  prod_ff <= prod_in;
      dvd_ff <= dvd_in;  rem_ff <= rem_in;  dneg_ff <= dneg_in;
      oidx_ff <= oidx_in;  ox_ff <= ox_in;  olast_ff <= olast_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign out_index  = oidx_ff;
   assign out_x      = ox_ff;
   assign out_last   = olast_ff;
endmodule

// File: hw/rtl/row_cell_legalizer_unit.sv
// ----------------------------------------------------------------------------
// row_cell_legalizer_unit
// Greedy push-right legalization of one placement row.
// ----------------------------------------------------------------------------
// Cells of a row stream in one per cycle; the transfer with tlast starts the
// work and the block stops taking cells until the row's results go out. Each
// row then runs a rank sort (one store read per compared pair plus setup,
// drain and write per cell), a row span setup, a sweep over the segments
// (one segment more than there are fixed cells) that places each movable
// cell, with a bit-serial remainder when snapping is on, and an emit step
// per result, which waits while the sink stalls. Results leave in load order,
// the last one flagged with tlast; the next row may start loading while that
// last result still waits at the output. Cells past MAX_CELLS in one row are
// dropped. Configure registers only while the block is idle.
module row_cell_legalizer_unit #(
   parameter int MAX_CELLS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // cell_x[31:0], cell_width[51:32], zero pad
   input  logic        req_tuser,   // cell_fixed
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // cell_index[5:0], new_x[37:6], zero pad
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import rcl_pkg::*;

   logic [X_W-1:0]    origin_ff, origin_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SCNT_W-1:0] count_ff, count_in;
   logic              csr_wr;
   reg_index_type     csr_idx;
   op_type            cmd;
   stat_type          stat;
   logic [IDX_W-1:0]  out_index;
   logic [X_W-1:0]    out_x;

   assign csr_pready = 1'b1;
   assign csr_wr  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx = reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      origin_in = origin_ff;
      step_in   = step_ff;
      count_in  = count_ff;
      csr_prdata = '0;
      unique case (csr_idx)
         REG_ORIGIN: begin
            csr_prdata = origin_ff;
            if (csr_wr) origin_in = csr_pwdata;
         end
         REG_STEP: begin
            csr_prdata = {16'd0, step_ff};
            if (csr_wr) step_in = csr_pwdata[STEP_W-1:0];
         end
         REG_COUNT: begin
            csr_prdata = {8'd0, count_ff};
            if (csr_wr) count_in = csr_pwdata[SCNT_W-1:0];
         end
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= '0;
         step_ff   <= 16'd1;
         count_ff  <= '0;
      end else begin
         origin_ff <= origin_in;
         step_ff   <= step_in;
         count_ff  <= count_in;
      end
   end

   rcl_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tlast, .stat, .req_tready, .cmd);

   rcl_dp #(.MAX_CELLS(MAX_CELLS)) u_dp (
      .clock, .reset, .cmd, .stat,
      .cfg_origin(origin_ff), .cfg_step(step_ff), .cfg_count(count_ff),
      .in_x(req_tdata[31:0]), .in_width(req_tdata[51:32]), .in_fixed(req_tuser),
      .rsp_tready, .rsp_tvalid, .out_index, .out_x, .out_last(rsp_tlast));

   assign rsp_tdata = {2'b00, out_x, out_index};

   // while cells load, only the previous row's final result may be pending
   a_load_pending_last: assert property (@(posedge clock) disable iff (reset)
      (req_tready && rsp_tvalid) |-> rsp_tlast)
      else $error("non-final result pending while loading");

   // the row-closing transfer stops further loading
   a_last_stops_load: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("cell accepted right after row end");
endmodule

// File: sim/tb_row_cell_legalizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_row_cell_legalizer_unit
// Streams placement rows into the legalizer and compares every emitted cell
// position with a push-right predictor kept in a small scoreboard, across
// several register settings and with random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_row_cell_legalizer_unit;
   import rcl_pkg::*;

   localparam int ROW_CAP = 64;

   typedef struct {
      logic [5:0]  index;
      logic [31:0] x;
      logic        last;
   } cell_result_type;

   class legalize_scoreboard;
      longint          origin;
      longint          step;
      longint          count;
      longint          row_x[$];
      longint          row_w[$];
      bit              row_f[$];
      cell_result_type pending_q[$];
      int              errors;

      function new();
         origin = 0;
         step   = 1;
         count  = 0;
         errors = 0;
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $time, msg);
         errors++;
      endtask

      function void set_reg(reg_index_type r, logic [31:0] v);
         case (r)
            REG_ORIGIN: origin = longint'($signed(v));
            REG_STEP:   step   = longint'(v[15:0]);
            REG_COUNT:  count  = longint'(v[23:0]);
            default: ;
         endcase
      endfunction

      // stable insert of cell id by x
      function void insert_by_x(ref int q[$], input int id);
         int p;
         p = q.size();
         while (p > 0 && row_x[q[p-1]] > row_x[id]) p--;
         q.insert(p, id);
      endfunction

      function void legalize_row();
         int fixed_q[$];
         int move_q[$];
         int k, mv, id, f;
         longint seg_l, seg_r, cursor, x, w, rb, snap, t;
         cell_result_type r;
         mv = 0;
         for (int i = 0; i < row_x.size(); i++)
            if (row_f[i]) insert_by_x(fixed_q, i);
         for (int i = 0; i < row_x.size(); i++)
            if (!row_f[i]) insert_by_x(move_q, i);
         for (k = 0; k <= fixed_q.size(); k++) begin
            if (k == 0) begin
               seg_l = origin;
            end else begin
               f = fixed_q[k-1];
               seg_l = row_x[f] + row_w[f];
            end
            seg_r = (k < fixed_q.size()) ? row_x[fixed_q[k]] : origin + step * count;
            if (seg_r <= seg_l) continue;
            cursor = seg_l;
            while (mv < move_q.size() && row_x[move_q[mv]] < seg_r) begin
               id = move_q[mv];
               x  = row_x[id];
               mv++;
               if (x >= seg_l) begin
                  w  = row_w[id];
                  rb = seg_r - w;
                  snap = (step != 0) ? origin + ((x - origin) / step) * step : x;
                  t = (cursor > snap) ? cursor : snap;
                  if (t > rb) t = rb;
                  if (t < seg_l) t = seg_l;
                  if (t > 64'sd2147483647) t = 64'sd2147483647;
                  if (t < -64'sd2147483648) t = -64'sd2147483648;
                  row_x[id] = t;
                  cursor = t + w;
               end
            end
         end
         for (int i = 0; i < row_x.size(); i++) begin
            r.index = i[5:0];
            r.x     = row_x[i][31:0];
            r.last  = (i == row_x.size() - 1);
            pending_q.insert(pending_q.size(), r);
         end
      endfunction

      function void note_cell(logic [31:0] x, logic [19:0] w, bit fixed_cell, bit last);
         if (row_x.size() < ROW_CAP) begin
            row_x.insert(row_x.size(), longint'($signed(x)));
            row_w.insert(row_w.size(), longint'(w));
            row_f.insert(row_f.size(), fixed_cell);
         end
         if (last) begin
            legalize_row();
            row_x.delete();
            row_w.delete();
            row_f.delete();
         end
      endfunction

      task check_result(logic [5:0] index, logic [31:0] x, logic last);
         cell_result_type e;
         if (pending_q.size() == 0) begin
            report($sformatf("unexpected result index %0d x %0d", index, $signed(x)));
            return;
         end
         e = pending_q.pop_front();
         if (index !== e.index)
            report($sformatf("cell_index %0d, want %0d", index, e.index));
         if (x !== e.x)
            report($sformatf("new_x of cell %0d is %0d, want %0d",
                             e.index, $signed(x), $signed(e.x)));
         if (last !== e.last)
            report($sformatf("last_result of cell %0d is %0b, want %0b",
                             e.index, last, e.last));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;   // cell_x[31:0], cell_width[51:32], zero pad
   logic        req_tuser;   // cell_fixed
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // cell_index[5:0], new_x[37:6], zero pad
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   legalize_scoreboard sb;
   int  send_idle_pct;
   int  sink_stall_pct;
   bit  sink_hold;
   int  cells_sent;

   row_cell_legalizer_unit u_top (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("Some tests failed");
      $finish;
   end

   always @(negedge clock)
      rsp_tready <= sink_hold ? 1'b0 : ($urandom_range(99) >= sink_stall_pct);

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_cell(req_tdata[31:0], req_tdata[51:32], req_tuser, req_tlast);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata[5:0], rsp_tdata[37:6], rsp_tlast);
      end
   end

   task automatic write_reg(reg_index_type r, logic [31:0] v);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {r, 2'b00};
      csr_pwdata  <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      sb.set_reg(r, v);
   endtask

   task automatic send_cell(logic [31:0] x, logic [19:0] w, bit fixed_cell, bit last);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, w, x};
      req_tuser  <= fixed_cell;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      cells_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   task automatic send_row(int n);
      longint span;
      logic [31:0] x;
      logic [19:0] w;
      span = (sb.step == 0) ? sb.count : sb.step * sb.count;
      if (span > 4000) span = 4000;
      for (int i = 0; i < n; i++) begin
         x = 32'(sb.origin + longint'($urandom_range(0, 32'(span + 40))) - 20);
         if ($urandom_range(9) == 0) x = $urandom;
         w = 20'($urandom_range(0, 40));
         if ($urandom_range(11) == 0) w = 20'($urandom);
         send_cell(x, w, $urandom_range(4) == 0, i == n - 1);
      end
   endtask

   task automatic random_config();
      logic [31:0] org;
      org = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 2000);
      write_reg(REG_ORIGIN, org);
      case ($urandom_range(4))
         0: write_reg(REG_STEP, 32'd0);
         1: write_reg(REG_STEP, 32'd1);
         2: write_reg(REG_STEP, 32'h0000ffff);
         default: write_reg(REG_STEP, $urandom_range(2, 16));
      endcase
      write_reg(REG_COUNT,
                ($urandom_range(9) == 0) ? 32'h00ffffff : $urandom_range(0, 300));
   endtask

   initial begin
      sb             = new();
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = 1'b0;
      req_tlast      = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      send_idle_pct  = 0;
      sink_stall_pct = 0;
      sink_hold      = 1'b0;
      cells_sent     = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: empty row span, the movable cell is clamped left of the fixed one
      send_cell(32'd5, 20'd3, 1'b0, 1'b0);
      send_cell(32'd7, 20'd1, 1'b1, 1'b1);
      drain();

      write_reg(REG_ORIGIN, 32'd1000);
      write_reg(REG_STEP, 32'd8);
      write_reg(REG_COUNT, 32'd100);
      send_cell(32'd1200, 20'd50, 1'b1, 1'b0);     // blockage splits the row
      send_cell(32'd1500, 20'd200, 1'b1, 1'b0);    // overlaps next: inverted segment
      send_cell(32'd1600, 20'd10, 1'b1, 1'b0);
      send_cell(32'd990, 20'd4, 1'b0, 1'b0);       // left of row
      send_cell(32'd1003, 20'd5, 1'b0, 1'b0);      // snaps down
      send_cell(32'd1003, 20'd7, 1'b0, 1'b0);      // tie, pushed right
      send_cell(32'd1190, 20'd30, 1'b0, 1'b0);     // clamped before blockage
      send_cell(32'd1260, 20'hfffff, 1'b0, 1'b0);  // wider than its segment
      send_cell(32'd1900, 20'd2, 1'b0, 1'b0);      // beyond the row
      send_cell(32'h7fffffff, 20'd1, 1'b0, 1'b0);
      send_cell(32'h80000000, 20'd1, 1'b0, 1'b1);
      drain();

      write_reg(REG_STEP, 32'd0);
      send_cell(32'd1013, 20'd9, 1'b0, 1'b0);
      send_cell(32'd1011, 20'd9, 1'b0, 1'b1);
      drain();

      // huge row: placed x saturates at the top of the range
      write_reg(REG_ORIGIN, 32'h80000000);
      write_reg(REG_STEP, 32'h0000ffff);
      write_reg(REG_COUNT, 32'h00ffffff);
      send_cell(32'h7ffffd00, 20'hfffff, 1'b0, 1'b0);
      send_cell(32'h7ffffe00, 20'hfffff, 1'b0, 1'b0);
      send_cell(32'h80000000, 20'd0, 1'b0, 1'b1);
      drain();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin send_idle_pct = 83; sink_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  sink_stall_pct = 83; end
            3: begin send_idle_pct = 23; sink_stall_pct = 23; end
            default: begin send_idle_pct = 0; sink_stall_pct = 0; end
         endcase
         random_config();
         if (phase == 4) begin
            // hold the sink off while rows keep coming
            fork
               begin
                  sink_hold = 1'b1;
                  repeat (3000) @(posedge clock);
                  sink_hold = 1'b0;
               end
            join_none
         end
         if (phase == 1) send_row(ROW_CAP + 2);   // row overflow drops the tail
         while (cells_sent < 20 + 46 * (phase + 1))
            send_row(($urandom_range(7) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8));
         drain();
      end

      if (sb.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
